// ----- rtl/fisheye_coordinate_remap_top_defines.svh -----
// assertion macros for the fisheye coordinate remap block
// used by fisheye_coordinate_remap_top, expects clk and rst_n in scope
`ifndef FISHEYE_COORDINATE_REMAP_TOP_DEFINES_SVH
`define FISHEYE_COORDINATE_REMAP_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define FCR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fcr assertion failed");
`define FCR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fcr assertion failed");
`else
`define FCR_ASSERT_NOW(lbl, ante, cons)
`define FCR_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- rtl/fcr_pkg.sv -----
// shared types and constants of the fisheye coordinate remap block
// no dependencies
package fcr_pkg;

  localparam int unsigned COORD_W   = 10;
  localparam int unsigned CFG_DW    = 32;
  localparam int unsigned CFG_IW    = 3;
  localparam int unsigned PIPE_DEPTH = 9;

  typedef logic [COORD_W-1:0] coord_t;

  typedef enum logic [CFG_IW-1:0] {
    CFG_ALPHA      = 3'd0,
    CFG_CENTER_ROW = 3'd1,
    CFG_CENTER_COL = 3'd2,
    CFG_ROW_SCALE  = 3'd3,
    CFG_COL_SCALE  = 3'd4,
    CFG_ROW_SHIFT  = 3'd5,
    CFG_COL_SHIFT  = 3'd6
  } cfg_idx_t;

  localparam logic [16:0] SCALE_ONE = 17'h10000;

endpackage

// ----- rtl/fcr_chan_if.sv -----
// valid/ready channels of the fisheye coordinate remap block
// depends on fcr_pkg
interface fcr_in_if import fcr_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t out_row;
  coord_t out_col;

  modport source (output valid, output out_row, output out_col, input ready);
  modport sink   (input valid, input out_row, input out_col, output ready);
endinterface

interface fcr_out_if import fcr_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t src_row;
  coord_t src_col;
  logic   inside_res;

  modport source (output valid, output src_row, output src_col, output inside_res,
                  input ready);
  modport sink   (input valid, input src_row, input src_col, input inside_res,
                  output ready);
endinterface

// ----- rtl/fisheye_coordinate_remap_top.sv -----
// fisheye coordinate remap: output pixel to source pixel, nine register stages
// depends on fcr_pkg, fcr_chan_if and fisheye_coordinate_remap_top_defines.svh
//
// Takes one output pixel coordinate per clock while in_chan.ready is high and returns the
// floored source coordinate and an inside flag (zero coordinates when outside the
// frame). Throughput is one beat per cycle without backpressure; the nine stages are:
// scale and shift, center offset, squares, radius sum, alpha product, k sum,
// offset products, magnitude sum with floor, and the final move and bounds check
// in the output register. Every stage holds under backpressure; in_chan.ready
// follows out_chan.ready through the stage valid bits. Configuration writes take
// effect at once and are meant to be made while no beat is in flight.
`include "fisheye_coordinate_remap_top_defines.svh"

module fisheye_coordinate_remap_top import fcr_pkg::*; #(
  parameter int unsigned FRAME_ROWS = 1024,
  parameter int unsigned FRAME_COLS = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  fcr_in_if.sink            in_chan,
  fcr_out_if.source         out_chan,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  // configuration registers
  logic [31:0] alpha_r;
  logic [19:0] ctr_row_r, ctr_col_r;
  logic [16:0] scl_row_r, scl_col_r;
  logic [19:0] shf_row_r, shf_col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r   <= '0;
      ctr_row_r <= '0;
      ctr_col_r <= '0;
      scl_row_r <= SCALE_ONE;
      scl_col_r <= SCALE_ONE;
      shf_row_r <= '0;
      shf_col_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ALPHA:      alpha_r   <= cfg_wdata;
        CFG_CENTER_ROW: ctr_row_r <= cfg_wdata[19:0];
        CFG_CENTER_COL: ctr_col_r <= cfg_wdata[19:0];
        CFG_ROW_SCALE:  scl_row_r <= cfg_wdata[16:0];
        CFG_COL_SCALE:  scl_col_r <= cfg_wdata[16:0];
        CFG_ROW_SHIFT:  shf_row_r <= cfg_wdata[19:0];
        CFG_COL_SHIFT:  shf_col_r <= cfg_wdata[19:0];
        default: ;
      endcase
    end
  end

  // stage valid bits and advance chain
  logic [PIPE_DEPTH-1:0] vld_r;
  logic [PIPE_DEPTH-1:0] adv;

  always_comb begin
    adv[PIPE_DEPTH-1] = !vld_r[PIPE_DEPTH-1] || out_chan.ready;
    for (int i = PIPE_DEPTH-2; i >= 0; i--) begin
      adv[i] = !vld_r[i] || adv[i+1];
    end
  end

  assign in_chan.ready = adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) vld_r[0] <= in_chan.valid;
      for (int i = 1; i < PIPE_DEPTH; i++) begin
        if (adv[i]) vld_r[i] <= vld_r[i-1];
      end
    end
  end

  // stage 1: scale and shift
  logic [26:0] prd_row, prd_col;
  logic [28:0] xs1_r, ys1_r;

  assign prd_row = in_chan.out_row * scl_row_r;
  assign prd_col = in_chan.out_col * scl_col_r;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      xs1_r <= {2'b00, prd_row} + {1'b0, shf_row_r, 8'h00};
      ys1_r <= {2'b00, prd_col} + {1'b0, shf_col_r, 8'h00};
    end
  end

  // stage 2: offset from center, sign and magnitude
  logic [29:0] dx, dy;
  logic [28:0] xs2_r, ys2_r, ax2_r, ay2_r;
  logic        nx2_r, ny2_r;

  assign dx = {1'b0, xs1_r} - {2'b00, ctr_row_r, 8'h00};
  assign dy = {1'b0, ys1_r} - {2'b00, ctr_col_r, 8'h00};

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      xs2_r <= xs1_r;
      ys2_r <= ys1_r;
      nx2_r <= dx[29];
      ny2_r <= dy[29];
      ax2_r <= dx[29] ? 29'(-dx) : dx[28:0];
      ay2_r <= dy[29] ? 29'(-dy) : dy[28:0];
    end
  end

  // stage 3: squares
  logic [57:0] sqx3_r, sqy3_r;
  logic [28:0] xs3_r, ys3_r, ax3_r, ay3_r;
  logic        nx3_r, ny3_r;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      sqx3_r <= ax2_r * ax2_r;
      sqy3_r <= ay2_r * ay2_r;
      xs3_r  <= xs2_r;
      ys3_r  <= ys2_r;
      ax3_r  <= ax2_r;
      ay3_r  <= ay2_r;
      nx3_r  <= nx2_r;
      ny3_r  <= ny2_r;
    end
  end

  // stage 4: squared radius
  logic [58:0] r2_4_r;
  logic [28:0] xs4_r, ys4_r, ax4_r, ay4_r;
  logic        nx4_r, ny4_r;

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      r2_4_r <= {1'b0, sqx3_r} + {1'b0, sqy3_r};
      xs4_r  <= xs3_r;
      ys4_r  <= ys3_r;
      ax4_r  <= ax3_r;
      ay4_r  <= ay3_r;
      nx4_r  <= nx3_r;
      ny4_r  <= ny3_r;
    end
  end

  // stage 5: alpha times squared radius, split in two halves
  logic [58:0] ahi5_r;
  logic [63:0] alo5_r;
  logic [28:0] xs5_r, ys5_r, ax5_r, ay5_r;
  logic        nx5_r, ny5_r;

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      ahi5_r <= alpha_r * r2_4_r[58:32];
      alo5_r <= alpha_r * r2_4_r[31:0];
      xs5_r  <= xs4_r;
      ys5_r  <= ys4_r;
      ax5_r  <= ax4_r;
      ay5_r  <= ay4_r;
      nx5_r  <= nx4_r;
      ny5_r  <= ny4_r;
    end
  end

  // stage 6: k, floored
  logic [58:0] k6_r;
  logic [28:0] xs6_r, ys6_r, ax6_r, ay6_r;
  logic        nx6_r, ny6_r;

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      k6_r  <= ahi5_r + {27'd0, alo5_r[63:32]};
      xs6_r <= xs5_r;
      ys6_r <= ys5_r;
      ax6_r <= ax5_r;
      ay6_r <= ay5_r;
      nx6_r <= nx5_r;
      ny6_r <= ny5_r;
    end
  end

  // stage 7: offset times k, split in two halves
  logic [55:0] mhx7_r, mhy7_r;
  logic [60:0] mlx7_r, mly7_r;
  logic [28:0] xs7_r, ys7_r;
  logic        nx7_r, ny7_r;

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      mhx7_r <= ax6_r * k6_r[58:32];
      mhy7_r <= ay6_r * k6_r[58:32];
      mlx7_r <= ax6_r * k6_r[31:0];
      mly7_r <= ay6_r * k6_r[31:0];
      xs7_r  <= xs6_r;
      ys7_r  <= ys6_r;
      nx7_r  <= nx6_r;
      ny7_r  <= ny6_r;
    end
  end

  // stage 8: move magnitude, rounded up for negative offsets with a remainder
  logic [57:0] mgx8_r, mgy8_r;
  logic [28:0] xs8_r, ys8_r;
  logic        nx8_r, ny8_r;
  logic        upx, upy;

  assign upx = nx7_r && (mlx7_r[31:0] != 32'd0);
  assign upy = ny7_r && (mly7_r[31:0] != 32'd0);

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      mgx8_r <= {2'b00, mhx7_r} + {29'd0, mlx7_r[60:32]} + {57'd0, upx};
      mgy8_r <= {2'b00, mhy7_r} + {29'd0, mly7_r[60:32]} + {57'd0, upy};
      xs8_r  <= xs7_r;
      ys8_r  <= ys7_r;
      nx8_r  <= nx7_r;
      ny8_r  <= ny7_r;
    end
  end

  // stage 9: source position, bounds check, output register
  logic [59:0] srx, sry;
  logic        inx, iny, in_frame;
  coord_t      src_row_r, src_col_r;
  logic        inside_r;

  assign srx = nx8_r ? ({31'd0, xs8_r} - {2'b00, mgx8_r})
                     : ({31'd0, xs8_r} + {2'b00, mgx8_r});
  assign sry = ny8_r ? ({31'd0, ys8_r} - {2'b00, mgy8_r})
                     : ({31'd0, ys8_r} + {2'b00, mgy8_r});
  assign inx = !srx[59] && (srx[58:16] < 43'(FRAME_ROWS));
  assign iny = !sry[59] && (sry[58:16] < 43'(FRAME_COLS));
  assign in_frame = inx && iny;

  always_ff @(posedge clk) begin
    if (adv[8]) begin
      src_row_r <= in_frame ? srx[25:16] : '0;
      src_col_r <= in_frame ? sry[25:16] : '0;
      inside_r  <= in_frame;
    end
  end

  assign out_chan.valid      = vld_r[PIPE_DEPTH-1];
  assign out_chan.src_row    = src_row_r;
  assign out_chan.src_col    = src_col_r;
  assign out_chan.inside_res = inside_r;

  // checks
  `FCR_ASSERT_NOW(a_stall_full, !in_chan.ready, out_chan.valid && !out_chan.ready)
  `FCR_ASSERT_NOW(a_black_zero, out_chan.valid && !inside_r, {src_row_r, src_col_r} == '0)
  `FCR_ASSERT_NEXT(a_beat_moves, vld_r[3] && adv[3], vld_r[4])

endmodule
